// ===== src/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and constants for the raw DPCM bit decoder
// Widths, the code length table, the squaring curve and the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

  localparam int PixW      = 16;
  localparam int PredW     = 18;
  localparam int LenW      = 4;
  localparam int BitsLeftW = 5;
  localparam int ZeroCntW  = 3;
  localparam int SumW      = 20;

  localparam int InTdataW  = 40;
  localparam int OutTdataW = 32;
  localparam int OutTuserW = 2;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;

  localparam int QueueDepth = 4;

  localparam int CurveSize = 256;
  localparam int CurveW    = 14;
  localparam int CurveNum  = 2000;
  localparam int CurveBias = 3969;
  localparam int CurveDiv  = 7938;

  localparam logic [LenW-1:0]      LenRaw   = 4'd14;
  localparam logic [BitsLeftW-1:0] RawBits  = 5'd16;
  localparam logic [ZeroCntW-1:0]  MaxZeros = 3'd5;

  localparam logic [CfgIndexW-1:0] CfgRowWidth    = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgSplitColumn = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgBlackOffset = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgUseCurve    = 2'd3;

  typedef struct packed {
    logic [PixW-1:0] row_width;
    logic [PixW-1:0] split_column;
    logic [PixW-1:0] black_offset;
    logic            use_curve;
  } cfg_t;

  // One decoded pixel on its way from the front to the back.
  typedef struct packed {
    logic [PredW-1:0] pred;
    logic [PixW-1:0]  col;
    logic [PixW-1:0]  black;  // signed row black for this column
    logic             last;
  } pixel_evt_t;

  // Prefix code to bit length.
  function automatic logic [LenW-1:0] code_len(input logic [3:0] idx);
    logic [LenW-1:0] n;
    unique case (idx)
      4'd0:    n = 4'd8;
      4'd1:    n = 4'd7;
      4'd2:    n = 4'd6;
      4'd3:    n = 4'd9;
      4'd4:    n = 4'd11;
      4'd5:    n = 4'd10;
      4'd6:    n = 4'd5;
      4'd7:    n = 4'd12;
      4'd8:    n = 4'd14;
      4'd9:    n = 4'd13;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  // Bits a pixel takes for a lane length: raw pixels take a full 16 bits.
  function automatic logic [BitsLeftW-1:0] data_bits(input logic [LenW-1:0] n);
    return (n == LenRaw) ? RawBits : BitsLeftW'(n);
  endfunction

  // Rounded v*v/3.969, evaluated only on constants to build the curve ROM.
  function automatic logic [CurveW-1:0] curve_calc(input int unsigned v);
    return CurveW'((CurveNum * v * v + CurveBias) / CurveDiv);
  endfunction

endpackage

`default_nettype wire

// ===== src/rpd_front.sv =====
// ----------------------------------------------------------------------------
// rpd_front: bit-level decoder
// Walks prefix codes and pixel bits one stream bit at a time, keeps the lane
// lengths and predictors, and emits one event per finished pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  rpd_pkg::cfg_t                cfg,
  input  logic                         fire,
  input  logic                         data_bit,
  input  logic                         row_start,
  input  logic [rpd_pkg::PixW-1:0]     black_left,
  input  logic [rpd_pkg::PixW-1:0]     black_right,
  output logic                         push,
  output rpd_pkg::pixel_evt_t          evt
);
  import rpd_pkg::*;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_SELECT = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [LenW-1:0]       even_len;
    logic [LenW-1:0]       odd_len;
    logic [BitsLeftW-1:0]  bits_left;
  } enter_t;

  // Set up decoding for a new column.
  function automatic enter_t enter_column(input logic [PixW-1:0] col,
                                          input logic [PixW-1:0] rw,
                                          input logic [LenW-1:0] el,
                                          input logic [LenW-1:0] ol);
    enter_t r;
    r.phase     = PH_DATA;
    r.even_len  = el;
    r.odd_len   = ol;
    r.bits_left = '0;
    if (col >= rw) begin
      r.phase = PH_DONE;
    end else begin
      if (col >= {rw[PixW-1:3], 3'b000}) begin
        r.even_len = LenRaw;
        r.odd_len  = LenRaw;
      end else if (col[2:0] == 3'b000) begin
        r.phase = PH_PREFIX;
      end
      if (r.phase == PH_DATA) begin
        r.bits_left = data_bits(col[0] ? r.odd_len : r.even_len);
      end
    end
    return r;
  endfunction

  phase_t                phase, phase_next;
  logic [ZeroCntW-1:0]   zero_count, zero_count_next;
  logic                  header_lane, header_lane_next;
  logic [LenW-1:0]       even_len, even_len_next;
  logic [LenW-1:0]       odd_len, odd_len_next;
  logic [BitsLeftW-1:0]  bits_left, bits_left_next;
  logic [PixW-1:0]       acc, acc_next;
  logic [PredW-1:0]      even_pred, even_pred_next;
  logic [PredW-1:0]      odd_pred, odd_pred_next;
  logic [PixW-1:0]       col, col_next;
  logic [PixW-1:0]       held_left, held_left_next;
  logic [PixW-1:0]       held_right, held_right_next;

  always_comb begin
    enter_t              ent;
    logic [ZeroCntW-1:0] zc_eff;
    logic [ZeroCntW-1:0] zc_m1;
    logic [LenW-1:0]     n;
    logic [LenW-1:0]     nn_m1;
    logic [PredW-1:0]    pred;
    logic [PredW-1:0]    offset;
    logic                tail;
    logic [PixW:0]       col_inc;

    phase_next       = phase;
    zero_count_next  = zero_count;
    header_lane_next = header_lane;
    even_len_next    = even_len;
    odd_len_next     = odd_len;
    bits_left_next   = bits_left;
    acc_next         = acc;
    even_pred_next   = even_pred;
    odd_pred_next    = odd_pred;
    col_next         = col;
    held_left_next   = held_left;
    held_right_next  = held_right;
    push             = 1'b0;
    evt              = '0;
    ent              = '0;
    zc_eff           = '0;
    zc_m1            = '0;
    n                = '0;
    nn_m1            = '0;
    pred             = '0;
    offset           = '0;
    tail             = 1'b0;
    col_inc          = '0;

    if (fire) begin
      // A row start restarts the row at column 0 before the bit is decoded.
      if (row_start) begin
        col_next        = '0;
        even_pred_next  = '0;
        odd_pred_next   = '0;
        held_left_next  = black_left;
        held_right_next = black_right;
        ent = enter_column('0, cfg.row_width, even_len_next, odd_len_next);
        phase_next       = ent.phase;
        even_len_next    = ent.even_len;
        odd_len_next     = ent.odd_len;
        bits_left_next   = ent.bits_left;
        acc_next         = '0;
        header_lane_next = 1'b0;
        zero_count_next  = '0;
      end

      unique case (phase_next)
        PH_PREFIX: begin
          if (data_bit) begin
            if (zero_count_next == '0) begin
              if (!header_lane_next) begin
                header_lane_next = 1'b1;
                zero_count_next  = '0;
              end else begin
                header_lane_next = 1'b0;
                phase_next       = PH_DATA;
                bits_left_next   = data_bits(col_next[0] ? odd_len_next : even_len_next);
                acc_next         = '0;
              end
            end else begin
              phase_next = PH_SELECT;
            end
          end else begin
            zero_count_next = zero_count_next + 1'b1;
            if (zero_count_next >= MaxZeros) begin
              zero_count_next = MaxZeros;
              phase_next      = PH_SELECT;
            end
          end
        end
        PH_SELECT: begin
          zc_eff = (zero_count_next >= 3'd1 && zero_count_next <= MaxZeros) ?
                   zero_count_next : 3'd1;
          zc_m1  = zc_eff - 1'b1;
          n      = code_len({zc_m1, data_bit});
          if (header_lane_next) odd_len_next = n;
          else                  even_len_next = n;
          if (!header_lane_next) begin
            header_lane_next = 1'b1;
            zero_count_next  = '0;
            phase_next       = PH_PREFIX;
          end else begin
            header_lane_next = 1'b0;
            phase_next       = PH_DATA;
            bits_left_next   = data_bits(col_next[0] ? odd_len_next : even_len_next);
            acc_next         = '0;
          end
        end
        PH_DATA: begin
          acc_next = {acc_next[PixW-2:0], data_bit};
          if (bits_left_next != '0) bits_left_next = bits_left_next - 1'b1;
          if (bits_left_next == '0) begin
            n    = col_next[0] ? odd_len_next : even_len_next;
            tail = col_next >= {cfg.row_width[PixW-1:3], 3'b000};
            if (tail || n == LenRaw) begin
              pred = {2'b00, acc_next};
            end else begin
              nn_m1  = (n == '0) ? '0 : n - 1'b1;
              offset = {2'b00, acc_next} + 18'd1 - (18'd1 << nn_m1);
              pred   = (col_next[0] ? odd_pred_next : even_pred_next) + offset;
            end
            if (col_next[0]) odd_pred_next = pred;
            else             even_pred_next = pred;

            col_inc    = {1'b0, col_next} + 17'd1;
            push       = 1'b1;
            evt.pred   = pred;
            evt.col    = col_next;
            evt.black  = (col_next >= cfg.split_column) ? held_right_next : held_left_next;
            evt.last   = (col_inc == {1'b0, cfg.row_width});

            col_next = col_inc[PixW-1:0];
            if (col_inc >= {1'b0, cfg.row_width}) begin
              phase_next = PH_DONE;
            end else begin
              ent = enter_column(col_inc[PixW-1:0], cfg.row_width,
                                 even_len_next, odd_len_next);
              phase_next       = ent.phase;
              even_len_next    = ent.even_len;
              odd_len_next     = ent.odd_len;
              bits_left_next   = ent.bits_left;
              acc_next         = '0;
              header_lane_next = 1'b0;
              zero_count_next  = '0;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PREFIX;
      zero_count  <= '0;
      header_lane <= 1'b0;
      even_len    <= LenRaw;
      odd_len     <= LenRaw;
      bits_left   <= '0;
      acc         <= '0;
      even_pred   <= '0;
      odd_pred    <= '0;
      col         <= '0;
      held_left   <= '0;
      held_right  <= '0;
    end else begin
      phase       <= phase_next;
      zero_count  <= zero_count_next;
      header_lane <= header_lane_next;
      even_len    <= even_len_next;
      odd_len     <= odd_len_next;
      bits_left   <= bits_left_next;
      acc         <= acc_next;
      even_pred   <= even_pred_next;
      odd_pred    <= odd_pred_next;
      col         <= col_next;
      held_left   <= held_left_next;
      held_right  <= held_right_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rpd_queue.sv =====
// ----------------------------------------------------------------------------
// rpd_queue: short pixel event queue
// Decouples the bit decoder from the black correction stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rpd_pkg::pixel_evt_t  wr_evt,
  input  logic                 pop,
  output rpd_pkg::pixel_evt_t  rd_evt,
  output logic                 full,
  output logic                 empty
);
  import rpd_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  pixel_evt_t      mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full   = (count == (PtrW+1)'(QueueDepth));
  assign empty  = (count == '0);
  assign rd_evt = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/rpd_back.sv =====
// ----------------------------------------------------------------------------
// rpd_back: curve and black correction
// Applies the optional squaring curve, shifts, subtracts the black offset, adds the row black,
// saturates, and holds the result in the output register.
`default_nettype none

module rpd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  rpd_pkg::cfg_t                     cfg,
  input  logic                              q_valid,
  input  rpd_pkg::pixel_evt_t               q_evt,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rpd_pkg::OutTdataW-1:0]     m_tdata,
  output logic [rpd_pkg::OutTuserW-1:0]     m_tuser,
  output logic                              m_tlast
);
  import rpd_pkg::*;

  logic [CurveW-1:0] curve_tbl [CurveSize];

  for (genvar i = 0; i < CurveSize; i++) begin : g_curve
    assign curve_tbl[i] = curve_calc(i);
  end

  logic [PixW-1:0]        pix;
  logic signed [SumW-1:0] sum;
  logic                   pos;
  logic [PixW-1:0]        sat;

  always_comb begin
    pix = q_evt.pred[PixW-1:0];
    if (cfg.use_curve && pix[PixW-1:8] == '0) begin
      pix = PixW'(curve_tbl[pix[7:0]]);
    end
    sum = $signed({2'b00, pix, 2'b00})
        - $signed({4'b0000, cfg.black_offset})
        + $signed({{4{q_evt.black[PixW-1]}}, q_evt.black});
    pos = (sum > 0);
    if (!pos)                             sat = '0;
    else if (sum[SumW-1:PixW] != '0)      sat = '1;
    else                                  sat = sum[PixW-1:0];
  end

  // Take a new event whenever the output register is free or drains.
  assign pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {q_evt.col, sat};
      m_tuser <= {|q_evt.pred[PredW-1:PixW], pos};
      m_tlast <= q_evt.last;
    end
  end

endmodule

`default_nettype wire

// ===== src/raw_photo_dpcm_bit_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// raw_photo_dpcm_bit_decoder_unit: bit-serial camera raw DPCM decoder
// Decodes one compressed bit per transfer into black-corrected pixels.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one compressed bit per transfer, MSB first, with
//   tuser flagging the first bit of a row; the row black values ride along
//   and are captured only on that first bit. The master stream emits one
//   transfer per finished pixel, tlast marking the row's final pixel.
//   Configuration is written through cfg_write/cfg_index/cfg_data while the
//   unit is idle; it takes effect on the next bit.
// Timing:
//   One bit is taken every cycle while the queue has room. A pixel's transfer
//   is offered once its event has entered the 4-entry event queue and then
//   been loaded into the output register. The bit decoder handles each bit
//   as it is taken, so the stream rate is one bit per cycle while not stalled.
// Reset:
//   Lengths go to 14, predictors, column and held blacks to zero, the
//   decoder waits for the even-lane prefix, configuration takes its defaults.
// Stall:
//   While the master side stalls, events gather in the queue; once it is
//   full, s_tready drops and incoming bits hold.
// ----------------------------------------------------------------------------
`default_nettype none

module raw_photo_dpcm_bit_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port
  input  logic                               cfg_write,
  input  logic [rpd_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [rpd_pkg::CfgDataW-1:0]       cfg_data,
  // Compressed bit stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [0] data_bit, [16:1] row_black_left, [32:17] row_black_right, rest zero
  input  logic [rpd_pkg::InTdataW-1:0]       s_tdata,
  // [0] row_start
  input  logic                               s_tuser,
  // Pixel stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] pixel_value, [31:16] column
  output logic [rpd_pkg::OutTdataW-1:0]      m_tdata,
  // [0] written, [1] range_error
  output logic [rpd_pkg::OutTuserW-1:0]      m_tuser,
  output logic                               m_tlast
);
  import rpd_pkg::*;

  cfg_t       cfg;
  logic       in_fire;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  pixel_evt_t push_evt;
  pixel_evt_t head_evt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width    <= 16'd8;
      cfg.split_column <= '0;
      cfg.black_offset <= '0;
      cfg.use_curve    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgRowWidth:    cfg.row_width    <= cfg_data[PixW-1:0];
        CfgSplitColumn: cfg.split_column <= cfg_data[PixW-1:0];
        CfgBlackOffset: cfg.black_offset <= cfg_data[PixW-1:0];
        CfgUseCurve:    cfg.use_curve    <= cfg_data[0];
        default:        cfg.use_curve    <= cfg.use_curve;
      endcase
    end
  end

  // Accept a bit whenever the queue can absorb a possible pixel event.
  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  rpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .fire        (in_fire),
    .data_bit    (s_tdata[0]),
    .row_start   (s_tuser),
    .black_left  (s_tdata[16:1]),
    .black_right (s_tdata[32:17]),
    .push        (q_push),
    .evt         (push_evt)
  );

  rpd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_evt (push_evt),
    .pop    (q_pop),
    .rd_evt (head_evt),
    .full   (q_full),
    .empty  (q_empty)
  );

  rpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (!q_empty),
    .q_evt    (head_evt),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Never write an event into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("pixel event pushed into full queue");

  // An event taken from the queue shows up on the output next cycle.
  a_pop_out: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid)
    else $error("popped event did not reach the output register");

  // A pixel that is not written carries a zero value.
  a_zero_unwritten: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[15:0] == 16'd0))
    else $error("unwritten pixel has a nonzero value");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the raw DPCM bit decoder
// Feeds compressed bits, one per transfer, and checks every pixel transfer
// against a bit-accurate decoder model kept inside the bench. A short table
// of directed bits comes first, then rows of random bits under a series of
// register settings, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb;
  import rpd_pkg::*;

  localparam int HalfPeriod    = 10;
  localparam int ResetCycles   = 6;
  localparam int WatchdogLimit = 5000;  // idle cycles before the run is ended
  localparam int SettleCycles  = 12;    // bits may still sit in the pipe with no pixel
  localparam int RandomItems   = 1700;
  localparam int NumSettings   = 12;

  // Decoder phases of the model.
  typedef enum logic [1:0] {PhPrefix, PhSelect, PhData, PhDone} dec_phase_t;

  // One compressed bit with its side fields.
  typedef struct packed {
    logic        b;
    logic        rs;
    logic [15:0] bl;
    logic [15:0] br;
  } bit_item_t;

  // One decoded pixel as it leaves the block.
  typedef struct packed {
    logic [15:0] value;
    logic [15:0] col;
    logic        written;
    logic        range_err;
    logic        last;
  } pixel_t;

  // Directed row: the bit, plus a typed-in pixel where one is obvious.
  typedef struct packed {
    bit_item_t item;
    logic      typed;
    pixel_t    px;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OutTdataW-1:0] m_tdata;
  logic [OutTuserW-1:0] m_tuser;
  logic                 m_tlast;

  always #HalfPeriod clk = ~clk;

  raw_photo_dpcm_bit_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [0] data_bit, [16:1] black left, [32:17] black right
    .s_tuser  (s_tuser),   // [0] row_start
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [15:0] pixel_value, [31:16] column
    .m_tuser  (m_tuser),   // [0] written, [1] range_error
    .m_tlast  (m_tlast)
  );

  // --------------------------------------------------------------------------
  // Decoder model: registers and state, at reset values
  // --------------------------------------------------------------------------
  logic [15:0] cfg_width = 16'd8;
  logic [15:0] cfg_split = 16'd0;
  logic [15:0] cfg_black = 16'd0;
  logic        cfg_curve = 1'b0;

  dec_phase_t  dec_phase   = PhPrefix;
  logic [2:0]  zero_run    = 3'd0;
  logic        lane_sel    = 1'b0;
  logic [3:0]  len_even    = LenRaw;
  logic [3:0]  len_odd     = LenRaw;
  logic [4:0]  bits_left   = 5'd0;
  logic [15:0] shift_acc   = 16'd0;
  logic [17:0] pred_even   = 18'd0;
  logic [17:0] pred_odd    = 18'd0;
  logic [15:0] col_cnt     = 16'd0;
  logic [15:0] black_left  = 16'd0;
  logic [15:0] black_right = 16'd0;

  // Prefix code index -> bit length
  logic [3:0] code_lengths [10] = '{4'd8, 4'd7, 4'd6, 4'd9, 4'd11,
                                   4'd10, 4'd5, 4'd12, 4'd14, 4'd13};

  pixel_t   expected_pixels [$];
  dir_row_t directed_rows [$];
  int       mismatches  = 0;
  logic     src_idle_on = 1'b1;

  // Arm the data phase for the current column's lane.
  task automatic load_pixel();
    logic [3:0] n;
    n = col_cnt[0] ? len_odd : len_even;
    dec_phase = PhData;
    bits_left = (n == LenRaw) ? RawBits : {1'b0, n};
    shift_acc = '0;
  endtask

  // Set up the column in col_cnt: done, tail (raw), header, or plain pixel.
  task automatic enter_column();
    if (col_cnt >= cfg_width) begin
      dec_phase = PhDone;
      return;
    end
    if (col_cnt >= (cfg_width & 16'hFFF8)) begin
      // tail lengths stick for later rows too
      len_even = LenRaw;
      len_odd  = LenRaw;
    end else if (col_cnt[2:0] == 3'd0) begin
      dec_phase = PhPrefix;
      lane_sel  = 1'b0;
      zero_run  = 3'd0;
      return;
    end
    load_pixel();
  endtask

  // Even lane header done -> odd lane header; odd done -> pixel bits.
  task automatic prefix_finished();
    if (!lane_sel) begin
      lane_sel  = 1'b1;
      zero_run  = 3'd0;
      dec_phase = PhPrefix;
    end else begin
      lane_sel = 1'b0;
      load_pixel();
    end
  endtask

  // Advance the model by one bit; got is high when a pixel completes.
  task automatic decode_bit(input bit_item_t it, output logic got, output pixel_t px);
    logic [2:0]        zc;
    logic [3:0]        n;
    logic [17:0]       p;
    logic              tail;
    logic signed [15:0] rb;
    logic [16:0]       next_col;
    int                idx;
    int                pix;
    int                v;
    got = 1'b0;
    px  = '0;
    if (it.rs) begin
      col_cnt     = '0;
      pred_even   = '0;
      pred_odd    = '0;
      black_left  = it.bl;
      black_right = it.br;
      lane_sel    = 1'b0;
      zero_run    = '0;
      bits_left   = '0;
      shift_acc   = '0;
      dec_phase   = PhPrefix;
      enter_column();
    end
    case (dec_phase)
      PhPrefix: begin
        if (it.b) begin
          if (zero_run == 3'd0) prefix_finished();
          else dec_phase = PhSelect;
        end else begin
          zero_run = zero_run + 3'd1;
          if (zero_run >= MaxZeros) begin
            zero_run  = MaxZeros;
            dec_phase = PhSelect;
          end
        end
        return;
      end
      PhSelect: begin
        zc  = (zero_run >= 3'd1 && zero_run <= MaxZeros) ? zero_run : 3'd1;
        idx = (int'(zc) - 1) * 2 + int'(it.b);
        n   = code_lengths[idx];
        if (lane_sel) len_odd = n;
        else len_even = n;
        prefix_finished();
        return;
      end
      PhDone: return;
      default: ;
    endcase

    shift_acc = {shift_acc[14:0], it.b};
    if (bits_left != 5'd0) bits_left = bits_left - 5'd1;
    if (bits_left != 5'd0) return;

    n    = col_cnt[0] ? len_odd : len_even;
    tail = col_cnt >= (cfg_width & 16'hFFF8);
    p    = col_cnt[0] ? pred_odd : pred_even;
    if (tail || n == LenRaw) p = {2'b00, shift_acc};
    else p = p + {2'b00, shift_acc} + 18'd1 - (18'd1 << (n - 4'd1));  // wraps mod 2^18
    if (col_cnt[0]) pred_odd = p;
    else pred_even = p;

    pix = int'(p[15:0]);
    if (cfg_curve && pix < CurveSize) pix = (CurveNum * pix * pix + CurveBias) / CurveDiv;
    rb = (col_cnt >= cfg_split) ? black_right : black_left;
    v  = pix * 4 - int'(cfg_black) + int'(rb);

    next_col     = {1'b0, col_cnt} + 17'd1;
    px.value     = (v <= 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
    px.col       = col_cnt;
    px.written   = v > 0;
    px.range_err = p[17:16] != 2'b00;
    px.last      = next_col == {1'b0, cfg_width};
    got          = 1'b1;

    col_cnt = next_col[15:0];
    if (next_col >= {1'b0, cfg_width}) dec_phase = PhDone;
    else enter_column();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Row black: lean on the signed extremes and small values.
  function automatic logic [15:0] black_pick();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Bit bias: 0/1 uniform, 2 mostly zeros (long prefixes, small raws),
  // 3 mostly ones.
  function automatic bit_item_t random_item(input int mode, input logic rs);
    bit_item_t it;
    case (mode)
      2: it.b = $urandom_range(0, 9) == 0;
      3: it.b = $urandom_range(0, 9) != 0;
      default: it.b = $urandom_range(0, 1);
    endcase
    it.rs = rs;
    if (rs) begin
      it.bl = black_pick();
      it.br = black_pick();
    end else begin
      // ignored off row start, but toggle the bits anyway
      it.bl = 16'($urandom);
      it.br = 16'($urandom);
    end
    return it;
  endfunction

  task automatic add_row(input logic b, input logic rs, input logic [15:0] bl,
                         input logic [15:0] br, input logic typed, input pixel_t px);
    dir_row_t row;
    row.item  = '{b: b, rs: rs, bl: bl, br: br};
    row.typed = typed;
    row.px    = px;
    directed_rows.push_back(row);
  endtask

  // Present one bit, hold it until the transfer, then predict. Call right
  // after a rising edge; s_tvalid is left high for a back-to-back bit.
  task automatic send_bit(input bit_item_t it, input logic typed, input pixel_t typed_px);
    int     gap;
    logic   got;
    pixel_t px;
    gap = (src_idle_on && $urandom_range(0, 1) == 0) ? idle_cycles() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= InTdataW'({it.br, it.bl, it.b});
    s_tuser  <= it.rs;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_bit(it, got, px);
    if (typed) expected_pixels.push_back(typed_px);
    else if (got) expected_pixels.push_back(px);
  endtask

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Pixel side: random backpressure, with quiet stretches of no stalls
  // --------------------------------------------------------------------------
  int          sink_hold = 0;
  logic        sink_free = 1'b0;
  int unsigned cyc       = 0;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 300 == 0) sink_free <= $urandom_range(0, 2) == 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else if (sink_free || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      sink_hold <= idle_cycles();
      m_tready  <= 1'b0;
    end
  end

  // Compare each pixel transfer with the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel transfer with none expected: column %0d value %0d",
                 $time, m_tdata[31:16], m_tdata[15:0]);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_value", want.value, m_tdata[15:0]);
        check_field("column", want.col, m_tdata[31:16]);
        check_field("written", want.written, m_tuser[0]);
        check_field("range_error", want.range_err, m_tuser[1]);
        check_field("last_in_row", want.last, m_tlast);
      end
    end
  end

  // Watchdog: end the run when neither stream moves for too long.
  int idle_run = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_run <= 0;
    end else if (idle_run >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d pixels outstanding",
               $time, idle_run, expected_pixels.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit_item_t   it;
    logic [15:0] w;
    logic [15:0] sp;
    logic [15:0] bo;
    logic        cu;
    int          quota;
    int          taken;
    int          raw;
    int          mode;
    int          abandon_at;
    int          nbits;

    // Directed table, default registers (width 8, split 0, no black, no curve).
    // Bits before any row start: decode as a row with zero predictors/blacks.
    add_row(1'b1, 1'b0, 16'h0, 16'h0, 1'b0, '0);   // even header: keep length 14
    add_row(1'b1, 1'b0, 16'h0, 16'h0, 1'b0, '0);   // odd header: keep length 14
    repeat (15) add_row(1'b1, 1'b0, 16'h0, 16'h0, 1'b0, '0);
    // raw all-ones pixel: 0xFFFF*4 saturates
    add_row(1'b1, 1'b0, 16'h0, 16'h0, 1'b1,
            pixel_t'{16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b0});
    add_row(1'b0, 1'b0, 16'h0, 16'h0, 1'b0, '0);   // first bit of column 1
    // Row start mid-pixel: abandon column 1, capture extreme blacks.
    add_row(1'b0, 1'b1, 16'h8000, 16'h7FFF, 1'b0, '0);
    repeat (4) add_row(1'b0, 1'b0, 16'h0, 16'h0, 1'b0, '0);  // five zeros, no stop bit
    add_row(1'b1, 1'b0, 16'h0, 16'h0, 1'b0, '0);   // last table entry: even -> 13
    add_row(1'b0, 1'b0, 16'h0, 16'h0, 1'b0, '0);   // one zero
    add_row(1'b1, 1'b0, 16'h0, 16'h0, 1'b0, '0);   // stop bit
    add_row(1'b0, 1'b0, 16'h0, 16'h0, 1'b0, '0);   // first table entry: odd -> 8

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_bit(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].px);

    for (int k = 1; k <= NumSettings; k++) begin
      case (k)
        1: begin w = 16'd1;     sp = 16'd0;     bo = 16'd0;     cu = 1'b1; end  // all tail
        2: begin w = 16'd0;     sp = 16'hFFFF;  bo = 16'hFFFF;  cu = 1'b0; end  // no pixels
        3: begin w = 16'hFFFF;  sp = 16'hFFFF;  bo = 16'd0;     cu = 1'b1; end  // never ends
        4: begin w = 16'd8;     sp = 16'd4;     bo = 16'hFFFF;  cu = 1'b0; end
        default: begin
          w  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(17, 70))
                                           : 16'($urandom_range(1, 16));
          sp = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(0, int'(w) + 1));
          bo = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
          cu = $urandom_range(0, 1);
        end
      endcase
      quota = (k == 2) ? 30 : RandomItems / (NumSettings - 1);

      // Registers change only with the block idle: drain pixels, then let
      // any header bits still in the pipe clear out.
      s_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clk);
      repeat (SettleCycles) @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= CfgRowWidth;
      cfg_data  <= w;
      @(posedge clk);
      cfg_index <= CfgSplitColumn;
      cfg_data  <= sp;
      @(posedge clk);
      cfg_index <= CfgBlackOffset;
      cfg_data  <= bo;
      @(posedge clk);
      cfg_index <= CfgUseCurve;
      cfg_data  <= CfgDataW'(cu);
      @(posedge clk);
      cfg_write <= 1'b0;
      cfg_width = w;
      cfg_split = sp;
      cfg_black = bo;
      cfg_curve = cu;

      // Rows: row start, random bits until the row is done; some rows are
      // cut short by an early row start, some trail a few ignored bits.
      taken = 0;
      raw   = 0;
      while (taken < quota && raw < 3 * quota + 40) begin
        mode        = $urandom_range(0, 3);
        src_idle_on = $urandom_range(0, 3) != 0;
        abandon_at  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 150) : 32'h4000_0000;
        if (cfg_width == 16'hFFFF) abandon_at = $urandom_range(20, 200);
        it = random_item(mode, 1'b1);
        send_bit(it, 1'b0, '0);
        taken++;
        raw++;
        nbits = 0;
        while (dec_phase != PhDone && nbits < abandon_at && taken < quota) begin
          it = random_item(mode, 1'b0);
          send_bit(it, 1'b0, '0);
          taken++;
          raw++;
          nbits++;
        end
        if (dec_phase == PhDone && $urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            it = random_item(mode, 1'b0);
            send_bit(it, 1'b0, '0);
            raw++;
          end
        end
      end
    end

    // Drain and give the pipe time to show any stray pixel.
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
